// File: rtl/core/hcbp_pkg.sv
// ----------------------------------------------------------------------------
// hcbp_pkg
// Shared types and constants for the code bit packer: table geometry,
// request function codes and the control state encoding.
// ----------------------------------------------------------------------------
package hcbp_pkg;

  localparam int TABLE_DEPTH      = 257;
  localparam int TABLE_ADDR_W     = $clog2(TABLE_DEPTH);
  localparam int END_MARKER       = 256;
  localparam int CODE_FIELD_W     = 32;
  localparam int LEN_W            = 6;
  localparam int BYTE_W           = 8;
  localparam int PEND_W           = BYTE_W - 1;
  localparam int FUNC_W           = 2;
  localparam int MAX_CODE_LEN_DEF = 32;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_ENCODE = 2'd1,
    FUNC_FINISH = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_EMIT
  } state_t;

endpackage

// File: rtl/core/hcbp_ram.sv
// ----------------------------------------------------------------------------
// hcbp_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module hcbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/huffman_code_bit_packer_unit.sv
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_unit
// Huffman encoder back end: code table plus LSB-first byte packer.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one request: in_func selects
//   load entry, encode symbol or finish stream. Loads write the code table
//   (257 entries, end marker at 256) and are taken every cycle while the
//   block is idle. Encode and finish read the table, merge the code into
//   the pending bits and send every completed byte on the output channel
//   (out_valid/out_ready), one byte per cycle while the receiver is ready,
//   earliest bit in bit 0. out_last_of_run marks the last byte of a
//   request; out_end_of_stream marks the final, zero-padded byte of a finish.
//   An encode or finish holds the input off through its table read
//   (ST_LOOKUP) and the emission of each completed byte (ST_EMIT); the
//   single table read port and the one-byte output register set this.
//   The output byte is registered. Reset: a clearing pass writes each of
//   the 257 table entries to length zero; in_ready stays low meanwhile.
//   A stalled receiver holds the output register and freezes byte
//   emission; the input waits in turn.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer_unit #(
  parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [hcbp_pkg::FUNC_W-1:0]   in_func,
  input  logic [8:0]                    in_symbol,
  input  logic [31:0]                   in_code_bits,
  input  logic [hcbp_pkg::LEN_W-1:0]    in_code_len,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hcbp_pkg::BYTE_W-1:0]   out_byte,
  output logic                          out_last_of_run,
  output logic                          out_end_of_stream
);

  import hcbp_pkg::*;

  // Stored code width: the cap on length, never above the 32-bit field.
  localparam int CODE_W  = (MAX_CODE_LEN < CODE_FIELD_W) ? MAX_CODE_LEN : CODE_FIELD_W;
  localparam int ENTRY_W = LEN_W + CODE_W;
  localparam int ACC_W   = PEND_W + CODE_W;
  localparam int FILL_W  = $clog2(ACC_W + 1);

  state_t              state_r, state_nxt;
  logic [TABLE_ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic                fin_r, fin_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]   out_byte_r, out_byte_nxt;
  logic                out_last_r, out_last_nxt;
  logic                out_eos_r, out_eos_nxt;

  // Table port signals
  logic                    ram_we;
  logic [TABLE_ADDR_W-1:0] ram_waddr;
  logic [ENTRY_W-1:0]      ram_wdata;
  logic                    ram_re;
  logic [TABLE_ADDR_W-1:0] ram_raddr;
  logic [ENTRY_W-1:0]      ram_rdata;

  // Load path
  logic [LEN_W-1:0]   len_sat;
  logic [CODE_W-1:0]  bits_masked;

  // Merge / emit path
  logic               in_fire;
  logic               sym_ok;
  logic [CODE_W-1:0]  rd_bits;
  logic [LEN_W-1:0]   rd_len;
  logic [ACC_W-1:0]   merged_acc;
  logic [FILL_W-1:0]  merged_fill;
  logic               merged_has;
  logic               has_byte;
  logic [FILL_W-1:0]  rem_fill;
  logic               more_bytes;
  logic               out_free;

  hcbp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign sym_ok   = (in_symbol <= 9'(END_MARKER));
  assign out_free = !out_valid_r || out_ready;

  // Saturate the length and drop code bits above it.
  always_comb begin
    len_sat = (in_code_len > LEN_W'(CODE_W)) ? LEN_W'(CODE_W) : in_code_len;
    for (int i = 0; i < CODE_W; i++) begin
      bits_masked[i] = in_code_bits[i] && (LEN_W'(i) < len_sat);
    end
  end

  // Table write: clearing pass after reset, else loads.
  always_comb begin
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = in_fire && (in_func == FUNC_LOAD) && sym_ok;
      ram_waddr = in_symbol[TABLE_ADDR_W-1:0];
      ram_wdata = {len_sat, bits_masked};
    end
  end

  // Table read: encode reads its symbol, finish reads the end marker.
  assign ram_re    = in_fire && (((in_func == FUNC_ENCODE) && sym_ok) ||
                                 (in_func == FUNC_FINISH));
  assign ram_raddr = (in_func == FUNC_FINISH) ? TABLE_ADDR_W'(END_MARKER)
                                              : in_symbol[TABLE_ADDR_W-1:0];

  // Merge the looked-up code above the pending bits.
  assign rd_bits     = ram_rdata[CODE_W-1:0];
  assign rd_len      = ram_rdata[ENTRY_W-1 -: LEN_W];
  assign merged_acc  = acc_r | (ACC_W'(rd_bits) << fill_r[2:0]);
  assign merged_fill = fill_r + FILL_W'(rd_len);
  assign merged_has  = (merged_fill >= FILL_W'(BYTE_W)) ||
                       (fin_r && (merged_fill != '0));

  // Byte emission from the accumulator.
  assign has_byte   = (fill_r >= FILL_W'(BYTE_W)) || (fin_r && (fill_r != '0));
  assign rem_fill   = (fill_r >= FILL_W'(BYTE_W)) ? fill_r - FILL_W'(BYTE_W) : '0;
  assign more_bytes = (rem_fill >= FILL_W'(BYTE_W)) || (fin_r && (rem_fill != '0));

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    acc_nxt       = acc_r;
    fill_nxt      = fill_r;
    fin_nxt       = fin_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_eos_nxt   = out_eos_r;

    case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + TABLE_ADDR_W'(1);
        if (clr_addr_r == TABLE_ADDR_W'(TABLE_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (ram_re) begin
          fin_nxt   = (in_func == FUNC_FINISH);
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (merged_has) begin
          acc_nxt   = merged_acc;
          fill_nxt  = merged_fill;
          state_nxt = ST_EMIT;
        end else begin
          // Nothing completed; keep the pending bits (finish has none here).
          acc_nxt   = fin_r ? '0 : merged_acc;
          fill_nxt  = fin_r ? '0 : merged_fill;
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (has_byte && out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = acc_r[BYTE_W-1:0];
          out_last_nxt  = !more_bytes;
          out_eos_nxt   = fin_r && !more_bytes;
          acc_nxt       = acc_r >> BYTE_W;
          fill_nxt      = rem_fill;
          if (!more_bytes) begin
            state_nxt = ST_IDLE;
            if (fin_r) begin
              acc_nxt  = '0;
              fill_nxt = '0;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      acc_r       <= '0;
      fill_r      <= '0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      acc_r       <= acc_nxt;
      fill_r      <= fill_nxt;
      fin_r       <= fin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload of the output register: no reset needed.
  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_eos_r  <= out_eos_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_byte          = out_byte_r;
  assign out_last_of_run   = out_last_r;
  assign out_end_of_stream = out_eos_r;

endmodule

// File: rtl/core/hcbp_checker.sv
// ----------------------------------------------------------------------------
// hcbp_checker
// Port-level checks for the code bit packer, bound to the top level.
// ----------------------------------------------------------------------------
module hcbp_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [hcbp_pkg::FUNC_W-1:0]   in_func,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [hcbp_pkg::BYTE_W-1:0]   out_byte,
  input logic                          out_last_of_run,
  input logic                          out_end_of_stream
);

  import hcbp_pkg::*;

  // Hold a stalled byte.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
      $stable(out_last_of_run) && $stable(out_end_of_stream))
    else $error("stalled output byte changed");

  // End of stream closes a request.
  a_eos_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_stream |-> out_last_of_run)
    else $error("end of stream without last of run");

  // Table clear runs right after reset.
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("request taken during table clear");

  // Loads never block the next request.
  a_load_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_func == FUNC_LOAD) |=> in_ready)
    else $error("load stalled the input");

  // A finish always goes through the table read and holds off the input.
  a_lookup_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_func == FUNC_FINISH) |=> !in_ready)
    else $error("finish skipped the table read");

endmodule

bind huffman_code_bit_packer_unit hcbp_checker u_hcbp_checker (.*);

// File: tb/tb_huffman_code_bit_packer_unit.sv
// ----------------------------------------------------------------------------
// tb_huffman_code_bit_packer_unit
// Self-checking bench for the code bit packer. A walk through a table of
// directed requests is followed by random load/encode/finish traffic in three
// flow-control phases. Every accepted request runs through a local model of
// the code table and the byte packer; each byte on the output channel is
// compared field by field against the oldest predicted byte.
// ----------------------------------------------------------------------------
module tb_huffman_code_bit_packer_unit;
  import hcbp_pkg::*;

  // Effective length cap of a stored code: the parameter, never above 32.
  localparam int LEN_CAP = (MAX_CODE_LEN_DEF < CODE_FIELD_W) ?
                           MAX_CODE_LEN_DEF : CODE_FIELD_W;
  localparam int PHASE_ITEMS = 45;
  localparam int DRAIN_GUARD = 20000;
  localparam int TAIL_CYCLES = 16;
  localparam int HOLD_CYCLES = 120;

  // One packed byte as seen on the output channel.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       eos;
  } packed_byte_t;

  // How a directed row is checked: against the model, or against a typed
  // value (no byte at all, or exactly one byte).
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_ONE
  } row_chk_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [8:0]  sym;
    logic [31:0] bits;
    logic [5:0]  len;
    row_chk_t    chk;
    logic [7:0]  data;
    logic        eos;
  } stim_row_t;

  localparam int N_ROWS = 25;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [FUNC_W-1:0]   in_func;
  logic [8:0]          in_symbol;
  logic [31:0]         in_code_bits;
  logic [LEN_W-1:0]    in_code_len;
  logic                out_valid;
  logic                out_ready;
  logic [BYTE_W-1:0]   out_byte;
  logic                out_last_of_run;
  logic                out_end_of_stream;

  // Local copy of the code table and the partial byte.
  logic [31:0]         tbl_bits [0:TABLE_DEPTH-1];
  int                  tbl_len  [0:TABLE_DEPTH-1];
  logic [PEND_W-1:0]   pend_bits;
  int                  pend_cnt;

  packed_byte_t        model_q[$];   // bytes caused by the latest request
  packed_byte_t        byte_q[$];    // bytes still owed by the block
  logic [8:0]          live_syms[$]; // symbols loaded with a nonzero length

  int                  err_cnt;
  int                  tx_idle_pct;
  int                  rx_idle_pct;
  int                  hold_left;

  // Directed requests. Typed expectations only where the byte is obvious:
  // nothing from an empty table, a plain 8-bit code, a short end marker.
  stim_row_t dir_rows [0:N_ROWS-1] = '{
    // unloaded symbol right after reset
    '{FUNC_ENCODE, 9'd0,   32'h0000_0000, 6'd0,  CHK_NONE,  8'h00, 1'b0},
    // empty finish: no end-marker code, nothing pending
    '{FUNC_FINISH, 9'd0,   32'h0000_0000, 6'd0,  CHK_NONE,  8'h00, 1'b0},
    // unused selector with every field at its top value
    '{FUNC_NONE,   9'd511, 32'hFFFF_FFFF, 6'd63, CHK_NONE,  8'h00, 1'b0},
    '{FUNC_LOAD,   9'd65,  32'h0000_00A5, 6'd8,  CHK_NONE,  8'h00, 1'b0},
    '{FUNC_ENCODE, 9'd65,  32'h0000_0000, 6'd0,  CHK_ONE,   8'hA5, 1'b0},
    '{FUNC_LOAD,   9'd256, 32'h0000_0005, 6'd3,  CHK_NONE,  8'h00, 1'b0},
    // finish pads the three end-marker bits into one byte
    '{FUNC_FINISH, 9'd0,   32'h0000_0000, 6'd0,  CHK_ONE,   8'h05, 1'b1},
    // long length saturates, all-ones code
    '{FUNC_LOAD,   9'd0,   32'hFFFF_FFFF, 6'd63, CHK_NONE,  8'h00, 1'b0},
    '{FUNC_ENCODE, 9'd0,   32'h0000_0000, 6'd0,  CHK_MODEL, 8'h00, 1'b0},
    // end marker encoded as a plain symbol, stream stays open
    '{FUNC_ENCODE, 9'd256, 32'h0000_0000, 6'd0,  CHK_MODEL, 8'h00, 1'b0},
    // out-of-range symbols are ignored on load and encode
    '{FUNC_LOAD,   9'd300, 32'h0000_FFFF, 6'd5,  CHK_NONE,  8'h00, 1'b0},
    '{FUNC_ENCODE, 9'd300, 32'h0000_0000, 6'd0,  CHK_NONE,  8'h00, 1'b0},
    '{FUNC_ENCODE, 9'd511, 32'h0000_0000, 6'd0,  CHK_NONE,  8'h00, 1'b0},
    '{FUNC_LOAD,   9'd255, 32'h0000_0000, 6'd32, CHK_NONE,  8'h00, 1'b0},
    '{FUNC_ENCODE, 9'd255, 32'h0000_0000, 6'd0,  CHK_MODEL, 8'h00, 1'b0},
    // high code bits beyond the length are dropped
    '{FUNC_LOAD,   9'd1,   32'hFFFF_FFF0, 6'd4,  CHK_NONE,  8'h00, 1'b0},
    '{FUNC_ENCODE, 9'd1,   32'h0000_0000, 6'd0,  CHK_MODEL, 8'h00, 1'b0},
    // seven bits pending plus a 32-bit end marker: five bytes from one finish
    '{FUNC_LOAD,   9'd256, 32'hFFFF_FFFF, 6'd32, CHK_NONE,  8'h00, 1'b0},
    '{FUNC_FINISH, 9'd0,   32'h0000_0000, 6'd0,  CHK_MODEL, 8'h00, 1'b0},
    '{FUNC_LOAD,   9'd2,   32'h1234_5678, 6'd33, CHK_NONE,  8'h00, 1'b0},
    '{FUNC_ENCODE, 9'd2,   32'h0000_0000, 6'd0,  CHK_MODEL, 8'h00, 1'b0},
    // zero-length end marker: finish only flushes what is pending
    '{FUNC_LOAD,   9'd256, 32'h0000_01FF, 6'd0,  CHK_NONE,  8'h00, 1'b0},
    '{FUNC_FINISH, 9'd0,   32'h0000_0000, 6'd0,  CHK_MODEL, 8'h00, 1'b0},
    '{FUNC_FINISH, 9'd0,   32'h0000_0000, 6'd0,  CHK_NONE,  8'h00, 1'b0},
    '{FUNC_ENCODE, 9'd3,   32'h0000_0000, 6'd0,  CHK_NONE,  8'h00, 1'b0}
  };

  huffman_code_bit_packer_unit u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_symbol         (in_symbol),
    .in_code_bits      (in_code_bits),
    .in_code_len       (in_code_len),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte          (out_byte),
    .out_last_of_run   (out_last_of_run),
    .out_end_of_stream (out_end_of_stream)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs or drops a handshake.
  initial begin
    #400000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    err_cnt++;
  endtask

  // Append a code to the partial byte and collect every byte it completes.
  function automatic void append_code(input logic [31:0] code, input int n);
    logic [39:0]  window;
    int           total;
    packed_byte_t pb;
    window = {33'd0, pend_bits} | ({8'd0, code} << pend_cnt);
    total  = pend_cnt + n;
    while (total >= BYTE_W) begin
      pb = '{data: window[7:0], last: 1'b0, eos: 1'b0};
      model_q.insert(model_q.size(), pb);
      window = window >> BYTE_W;
      total -= BYTE_W;
    end
    pend_bits = window[PEND_W-1:0];
    pend_cnt  = total;
  endfunction

  // Apply one request to the local table and packer; leave its bytes in
  // model_q with the run and stream flags set.
  function automatic void pack_request(input logic [1:0] f, input logic [8:0] s,
                                       input logic [31:0] b, input logic [5:0] l);
    int           cap_len;
    logic [63:0]  mask;
    packed_byte_t pb;
    model_q.delete();
    case (f)
      FUNC_LOAD: begin
        if (s < TABLE_DEPTH) begin
          cap_len     = (l > LEN_CAP) ? LEN_CAP : int'(l);
          mask        = (64'd1 << cap_len) - 64'd1;
          tbl_bits[s] = b & mask[31:0];
          tbl_len[s]  = cap_len;
        end
      end
      FUNC_ENCODE: begin
        if (s < TABLE_DEPTH) append_code(tbl_bits[s], tbl_len[s]);
      end
      FUNC_FINISH: begin
        append_code(tbl_bits[END_MARKER], tbl_len[END_MARKER]);
        if (pend_cnt != 0) begin
          pb = '{data: {1'b0, pend_bits}, last: 1'b0, eos: 1'b0};
          model_q.insert(model_q.size(), pb);
        end
        pend_bits = '0;
        pend_cnt  = 0;
        if (model_q.size() > 0) model_q[model_q.size()-1].eos = 1'b1;
      end
      default: ;
    endcase
    if (model_q.size() > 0) model_q[model_q.size()-1].last = 1'b1;
  endfunction

  // Offer one request and hold it until accepted. Idle gaps come first so
  // valid never drops once raised.
  task automatic send_req(input logic [1:0] f, input logic [8:0] s,
                          input logic [31:0] b, input logic [5:0] l);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_func      <= f;
    in_symbol    <= s;
    in_code_bits <= b;
    in_code_len  <= l;
    do @(posedge clk); while (!in_ready);
  endtask

  // Wait until every predicted byte has come back, bounded.
  task automatic wait_drained();
    int guard;
    guard = 0;
    while (byte_q.size() != 0 && guard < DRAIN_GUARD) begin
      @(posedge clk);
      guard++;
    end
  endtask

  // Receiver: random ready, with one long hold-off on request so the block
  // backs up and stalls its input.
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Compare every accepted byte against the oldest prediction.
  always @(posedge clk) begin
    packed_byte_t want;
    if (rst_n && out_valid && out_ready) begin
      if (byte_q.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h", out_byte));
      end else begin
        want = byte_q.pop_front();
        if (out_byte !== want.data)
          report_mismatch($sformatf("byte %02h, want %02h", out_byte, want.data));
        if (out_last_of_run !== want.last)
          report_mismatch($sformatf("last_of_run %b, want %b",
                                    out_last_of_run, want.last));
        if (out_end_of_stream !== want.eos)
          report_mismatch($sformatf("end_of_stream %b, want %b",
                                    out_end_of_stream, want.eos));
      end
    end
  end

  // Main stimulus.
  initial begin
    logic [1:0]   f;
    logic [8:0]   s;
    logic [31:0]  b;
    logic [5:0]   l;
    int           pick;
    packed_byte_t row_pb;

    in_valid     <= 1'b0;
    in_func      <= FUNC_LOAD;
    in_symbol    <= '0;
    in_code_bits <= '0;
    in_code_len  <= '0;
    rst_n        <= 1'b0;
    err_cnt      = 0;
    hold_left    = 0;
    tx_idle_pct  = 18;
    rx_idle_pct  = 63;
    pend_bits    = '0;
    pend_cnt     = 0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      tbl_bits[i] = '0;
      tbl_len[i]  = 0;
    end

    // Hold reset low, then release it; the clearing pass shows up as in_ready low.
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table: typed rows still advance the model, but queue the
    // hand-written expectation instead of the model's.
    for (int i = 0; i < N_ROWS; i++) begin
      send_req(dir_rows[i].func, dir_rows[i].sym, dir_rows[i].bits, dir_rows[i].len);
      pack_request(dir_rows[i].func, dir_rows[i].sym, dir_rows[i].bits,
                   dir_rows[i].len);
      case (dir_rows[i].chk)
        CHK_MODEL: foreach (model_q[k]) byte_q.insert(byte_q.size(), model_q[k]);
        CHK_ONE: begin
          row_pb = '{data: dir_rows[i].data, last: 1'b1, eos: dir_rows[i].eos};
          byte_q.insert(byte_q.size(), row_pb);
        end
        default:   ;
      endcase
      if (dir_rows[i].func == FUNC_LOAD && dir_rows[i].sym < TABLE_DEPTH &&
          dir_rows[i].len != 0)
        live_syms.insert(live_syms.size(), dir_rows[i].sym);
    end
    wait_drained();

    // Random traffic: mostly encodes of loaded symbols, with loads, finishes
    // and some noise mixed in. Phase 0: slow receiver, phase 1: slow sender,
    // phase 2: full rate with one long receiver hold-off.
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0:       begin tx_idle_pct = 18; rx_idle_pct = 63; end
        1:       begin tx_idle_pct = 63; rx_idle_pct = 18; end
        default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  hold_left = HOLD_CYCLES; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 99);
        b    = $urandom;
        l    = '0;
        s    = '0;
        if (pick < 14) begin
          f = FUNC_LOAD;
          s = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(257, 511))
                                          : 9'($urandom_range(0, 256));
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: l = 6'($urandom_range(1, 9));
            6, 7:             l = 6'($urandom_range(10, 32));
            default:          l = 6'($urandom_range(0, 63));
          endcase
          if (s < TABLE_DEPTH && l != 0) live_syms.insert(live_syms.size(), s);
        end else if (pick < 84) begin
          f = FUNC_ENCODE;
          if (live_syms.size() > 0 && $urandom_range(0, 9) < 8)
            s = live_syms[$urandom_range(0, live_syms.size() - 1)];
          else
            s = 9'($urandom_range(0, 511));
        end else if (pick < 95) begin
          f = FUNC_FINISH;
          s = 9'($urandom_range(0, 511));
        end else begin
          f = FUNC_NONE;
          s = 9'($urandom_range(0, 511));
          l = 6'($urandom_range(0, 63));
        end
        send_req(f, s, b, l);
        pack_request(f, s, b, l);
        foreach (model_q[k]) byte_q.insert(byte_q.size(), model_q[k]);
      end
    end
    in_valid <= 1'b0;

    // Drain, run out the tail, then check for bytes that never arrived and call it.
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (byte_q.size() != 0)
      report_mismatch($sformatf("%0d predicted bytes never arrived", byte_q.size()));
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/hcbp_pkg.sv
rtl/core/hcbp_ram.sv
rtl/core/huffman_code_bit_packer_unit.sv
rtl/core/hcbp_checker.sv
tb/tb_huffman_code_bit_packer_unit.sv
